// File: rtl/core/c_word_classifier_defines.svh
// Assertion macros shared by the word classifier modules.
// Both expect clk and rst_n in scope.
`ifndef C_WORD_CLASSIFIER_DEFINES_SVH
`define C_WORD_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define CWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word classifier check failed");

// next-cycle implication
`define CWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word classifier check failed");

`endif

// File: rtl/core/cwc_pkg.sv
package cwc_pkg;

    localparam int MATCH_LEN = 16;
    localparam int CNT_W     = $clog2(MATCH_LEN + 2);
    localparam int IDX_W     = $clog2(MATCH_LEN);
    localparam int LINE_W    = 32;
    localparam int LEN_W     = 5;
    localparam int CLS_W     = 3;

    localparam int TOK_MAX   = 14;
    localparam int TOK_LEN_W = 4;
    localparam int KW_COUNT  = 44;
    localparam int PU_COUNT  = 16;
    localparam int OP_COUNT  = 36;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CLS_W-1:0] CLS_KEYWORD = 3'd0;
    localparam logic [CLS_W-1:0] CLS_PUNCT   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_OPER    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_IDENT   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd4;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_UNDER   = 8'd95;

    typedef logic [MATCH_LEN-1:0][7:0] word_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [LINE_W-1:0]         line_t;
    typedef logic [TOK_MAX*8-1:0]      tok_text_t;

    typedef struct packed {
        word_t text;
        cnt_t  count;
        logic  ident_ok;
        line_t line;
    } word_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // text is right-aligned: last char in the low byte
    typedef struct packed {
        logic [TOK_LEN_W-1:0] len;
        tok_text_t            text;
    } tok_entry_t;

    localparam tok_entry_t KW_TABLE [KW_COUNT] = '{
        '{4'd4,  tok_text_t'("auto")},     '{4'd5,  tok_text_t'("break")},
        '{4'd4,  tok_text_t'("case")},     '{4'd4,  tok_text_t'("char")},
        '{4'd5,  tok_text_t'("const")},    '{4'd8,  tok_text_t'("continue")},
        '{4'd7,  tok_text_t'("default")},  '{4'd2,  tok_text_t'("do")},
        '{4'd6,  tok_text_t'("double")},   '{4'd4,  tok_text_t'("else")},
        '{4'd4,  tok_text_t'("enum")},     '{4'd6,  tok_text_t'("extern")},
        '{4'd5,  tok_text_t'("float")},    '{4'd3,  tok_text_t'("for")},
        '{4'd4,  tok_text_t'("goto")},     '{4'd2,  tok_text_t'("if")},
        '{4'd6,  tok_text_t'("inline")},   '{4'd3,  tok_text_t'("int")},
        '{4'd4,  tok_text_t'("long")},     '{4'd8,  tok_text_t'("register")},
        '{4'd8,  tok_text_t'("restrict")}, '{4'd6,  tok_text_t'("return")},
        '{4'd5,  tok_text_t'("short")},    '{4'd6,  tok_text_t'("signed")},
        '{4'd6,  tok_text_t'("sizeof")},   '{4'd6,  tok_text_t'("static")},
        '{4'd6,  tok_text_t'("struct")},   '{4'd6,  tok_text_t'("switch")},
        '{4'd7,  tok_text_t'("typedef")},  '{4'd5,  tok_text_t'("union")},
        '{4'd8,  tok_text_t'("unsigned")}, '{4'd4,  tok_text_t'("void")},
        '{4'd8,  tok_text_t'("volatile")}, '{4'd5,  tok_text_t'("while")},
        '{4'd8,  tok_text_t'("_Alignas")}, '{4'd8,  tok_text_t'("_Alignof")},
        '{4'd7,  tok_text_t'("_Atomic")},  '{4'd5,  tok_text_t'("_Bool")},
        '{4'd8,  tok_text_t'("_Complex")}, '{4'd8,  tok_text_t'("_Generic")},
        '{4'd10, tok_text_t'("_Imaginary")},
        '{4'd9,  tok_text_t'("_Noreturn")},
        '{4'd14, tok_text_t'({"_Static", "_assert"})},
        '{4'd13, tok_text_t'({"_Thread", "_local"})}
    };

    localparam tok_entry_t PU_TABLE [PU_COUNT] = '{
        '{4'd1, tok_text_t'("{")},  '{4'd1, tok_text_t'("}")},
        '{4'd1, tok_text_t'("[")},  '{4'd1, tok_text_t'("]")},
        '{4'd1, tok_text_t'("(")},  '{4'd1, tok_text_t'(")")},
        '{4'd1, tok_text_t'("#")},  '{4'd2, tok_text_t'("##")},
        '{4'd1, tok_text_t'(";")},  '{4'd1, tok_text_t'(":")},
        '{4'd1, tok_text_t'("?")},  '{4'd1, tok_text_t'(".")},
        '{4'd2, tok_text_t'("->")}, '{4'd1, tok_text_t'(",")},
        '{4'd3, tok_text_t'("...")}, '{4'd1, tok_text_t'("@")}
    };

    localparam tok_entry_t OP_TABLE [OP_COUNT] = '{
        '{4'd1, tok_text_t'("+")},   '{4'd1, tok_text_t'("-")},
        '{4'd1, tok_text_t'("*")},   '{4'd1, tok_text_t'("/")},
        '{4'd1, tok_text_t'("%")},   '{4'd2, tok_text_t'("++")},
        '{4'd2, tok_text_t'("--")},  '{4'd1, tok_text_t'("=")},
        '{4'd2, tok_text_t'("+=")},  '{4'd2, tok_text_t'("-=")},
        '{4'd2, tok_text_t'("*=")},  '{4'd2, tok_text_t'("/=")},
        '{4'd2, tok_text_t'("%=")},  '{4'd2, tok_text_t'("&=")},
        '{4'd2, tok_text_t'("|=")},  '{4'd2, tok_text_t'("^=")},
        '{4'd3, tok_text_t'("<<=")}, '{4'd3, tok_text_t'(">>=")},
        '{4'd2, tok_text_t'("==")},  '{4'd2, tok_text_t'("!=")},
        '{4'd1, tok_text_t'(">")},   '{4'd1, tok_text_t'("<")},
        '{4'd2, tok_text_t'(">=")},  '{4'd2, tok_text_t'("<=")},
        '{4'd2, tok_text_t'("&&")},  '{4'd2, tok_text_t'("||")},
        '{4'd1, tok_text_t'("!")},   '{4'd1, tok_text_t'("&")},
        '{4'd1, tok_text_t'("|")},   '{4'd1, tok_text_t'("^")},
        '{4'd1, tok_text_t'("~")},   '{4'd2, tok_text_t'("<<")},
        '{4'd2, tok_text_t'(">>")},  '{4'd1, tok_text_t'("?")},
        '{4'd1, tok_text_t'(":")},   '{4'd1, tok_text_t'(".")}
    };

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic tok_match(word_t w, cnt_t n, tok_entry_t e);
        logic hit;
        hit = (n == cnt_t'(e.len));
        for (int i = 0; i < TOK_MAX; i++)
        begin
            if ((i < int'(e.len)) && (w[i] != e.text[8*(int'(e.len) - 1 - i) +: 8]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic [CLS_W-1:0] classify(word_rec_t r);
        logic kw;
        logic pu;
        logic op;
        kw = 1'b0;
        pu = 1'b0;
        op = 1'b0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            kw = kw | tok_match(r.text, r.count, KW_TABLE[i]);
        end
        for (int i = 0; i < PU_COUNT; i++)
        begin
            pu = pu | tok_match(r.text, r.count, PU_TABLE[i]);
        end
        for (int i = 0; i < OP_COUNT; i++)
        begin
            op = op | tok_match(r.text, r.count, OP_TABLE[i]);
        end
        if (kw)
        begin
            return CLS_KEYWORD;
        end
        else if (pu)
        begin
            return CLS_PUNCT;
        end
        else if (op)
        begin
            return CLS_OPER;
        end
        else if (r.ident_ok)
        begin
            return CLS_IDENT;
        end
        return CLS_UNKNOWN;
    endfunction

endpackage

// File: rtl/core/cwc_word_fifo.sv
`include "c_word_classifier_defines.svh"

module cwc_word_fifo
    import cwc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  word_rec_t wr_rec,
    input  logic      pop,
    output word_rec_t rd_rec,
    output q_status_t status
);

    word_rec_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   fill_reg;
    logic [Q_CNT_W-1:0]   fill_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    assign rd_rec       = mem[rd_ptr_reg];
    assign status.full  = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (fill_reg == '0);

    `CWC_ASSERT_NOW(a_no_overflow, push, !status.full)
    `CWC_ASSERT_NOW(a_no_underflow, pop, !status.empty)

endmodule

// File: rtl/core/cwc_word_front.sv
`include "c_word_classifier_defines.svh"

module cwc_word_front
    import cwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    input  q_status_t  q_status,
    output logic       push,
    output word_rec_t  rec
);

    word_t text_reg;
    cnt_t  count_reg;
    cnt_t  count_next;
    logic  ident_reg;
    logic  ident_next;
    line_t line_reg;
    line_t line_next;
    logic  accept;
    logic  word_end;
    logic  char_ok;
    logic  buf_wr;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign word_end = end_of_text || is_space(char_code);
    assign push     = accept && word_end && (count_reg != '0);
    assign buf_wr   = accept && !word_end && (count_reg < cnt_t'(MATCH_LEN));

    always_comb
    begin
        char_ok    = (count_reg == '0) ? (is_letter(char_code) || char_code == CH_UNDER)
                   : (is_letter(char_code) || is_digit(char_code) || char_code == CH_UNDER);
        count_next = count_reg;
        ident_next = ident_reg;
        line_next  = line_reg;
        if (accept)
        begin
            if (word_end)
            begin
                count_next = '0;
                ident_next = 1'b1;
                if (!end_of_text && char_code == CH_NEWLINE && line_reg != '1)
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            else
            begin
                ident_next = ident_reg && char_ok;
                if (count_reg <= cnt_t'(MATCH_LEN))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ident_reg <= 1'b1;
            line_reg  <= line_t'(1);
        end
        else
        begin
            count_reg <= count_next;
            ident_reg <= ident_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            text_reg[count_reg[IDX_W-1:0]] <= char_code;
        end
    end

    assign rec.text     = text_reg;
    assign rec.count    = count_reg;
    assign rec.ident_ok = ident_reg;
    assign rec.line     = line_reg;

    `CWC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= cnt_t'(MATCH_LEN + 1))
    `CWC_ASSERT_NEXT(a_clear_after_flush, push, count_reg == '0 && ident_reg)

endmodule

// File: rtl/core/cwc_match_back.sv
module cwc_match_back
    import cwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  word_rec_t         rd_rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CLS_W-1:0]  token_class,
    output line_t             line_num,
    output logic [LEN_W-1:0]  word_length
);

    logic             valid_reg;
    logic             valid_next;
    logic [CLS_W-1:0] class_reg;
    line_t            line_reg;
    logic [LEN_W-1:0] len_reg;

    assign pop = !q_status.empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            class_reg <= classify(rd_rec);
            line_reg  <= rd_rec.line;
            len_reg   <= LEN_W'(rd_rec.count);
        end
    end

    assign out_valid   = valid_reg;
    assign token_class = class_reg;
    assign line_num    = line_reg;
    assign word_length = len_reg;

endmodule

// File: rtl/core/c_word_classifier.sv
// Word classifier for C text. One text byte (or an end-of-text flag) per beat; whitespace ends
// a word and each finished word yields one beat: class, line number and length. The block
// takes one byte per cycle while the queue has room. A word's table lookup runs in the match
// stage as it leaves the two-entry word queue; the queue and the output register let input
// continue while the output side stalls, and input stalls only once both queue entries hold
// unread words. Words beyond sixteen bytes report length 17 and never match a table entry.
module c_word_classifier
    import cwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [2:0] token_class, [34:3] line number,
                                        // [39:35] word_length
);

    q_status_t        q_status;
    logic             push;
    logic             pop;
    word_rec_t        wr_rec;
    word_rec_t        rd_rec;
    logic [CLS_W-1:0] token_class;
    line_t            line_num;
    logic [LEN_W-1:0] word_length;

    cwc_word_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .char_code   (s_axis_tdata),
        .end_of_text (s_axis_tuser),
        .q_status    (q_status),
        .push        (push),
        .rec         (wr_rec)
    );

    cwc_word_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .status (q_status)
    );

    cwc_match_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .rd_rec      (rd_rec),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .token_class (token_class),
        .line_num    (line_num),
        .word_length (word_length)
    );

    assign m_axis_tdata = {word_length, line_num, token_class};

endmodule
